// ===== src/float_sqrt_magic_newton_macros.svh =====
// Assertion macros shared by the float_sqrt_magic_newton RTL.
// Uses the clk and arst_n names of the including module; no other dependencies.
`ifndef FLOAT_SQRT_MAGIC_NEWTON_MACROS_SVH
`define FLOAT_SQRT_MAGIC_NEWTON_MACROS_SVH
`ifndef SYNTHESIS
// check on every edge outside reset
`define FSMN_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// check on every edge, reset included
`define FSMN_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FSMN_ASSERT(lbl, prop, msg)
`define FSMN_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== src/fsmn_pkg.sv =====
// Shared types, constants and binary32 helper functions for the square root pipeline.
// No dependencies.
package fsmn_pkg;

	localparam int NEWTON_STEPS_DEF = 2;
	localparam logic [31:0] SEED_ADD = 32'h1fbd1df5;
	localparam logic [31:0] CANON_NAN = 32'h7fc00000;

	// pipeline depths of the arithmetic units
	localparam int MUL_LAT = 3;
	localparam int ADD_LAT = 5;
	localparam int DIV_QB = 27;
	localparam int DIV_LAT = DIV_QB + 3;
	localparam int STEP_LAT = MUL_LAT + 2 * ADD_LAT + DIV_LAT;

	// unpacked operand: value = m / 2^23 * 2^e, m[23] set for any finite nonzero
	typedef struct packed {
		logic sign;
		logic zero;
		logic inf;
		logic nan;
		logic signed [10:0] e;
		logic [23:0] m;
	} fp_unp_t;

	function automatic logic [4:0] lzc23(input logic [22:0] v);
		logic [4:0] c;
		c = 5'd0;
		for (int i = 0; i < 23; i++) begin
			if (v[i]) c = 5'(22 - i);
		end
		return c;
	endfunction

	function automatic logic [4:0] lzc27(input logic [26:0] v);
		logic [4:0] c;
		c = 5'd0;
		for (int i = 0; i < 27; i++) begin
			if (v[i]) c = 5'(26 - i);
		end
		return c;
	endfunction

	// normalize subnormals so every finite nonzero operand has its leading one at bit 23
	function automatic fp_unp_t unpack(input logic [31:0] b);
		fp_unp_t u;
		logic [4:0] lz;
		u.sign = b[31];
		u.nan = (b[30:23] == 8'hff) && (b[22:0] != 23'd0);
		u.inf = (b[30:23] == 8'hff) && (b[22:0] == 23'd0);
		u.zero = (b[30:23] == 8'h00) && (b[22:0] == 23'd0);
		lz = lzc23(b[22:0]);
		if (b[30:23] != 8'h00) begin
			u.m = {1'b1, b[22:0]};
			u.e = $signed({3'b000, b[30:23]}) - 11'sd127;
		end else begin
			u.m = {b[22:0], 1'b0} << lz;
			u.e = -11'sd127 - $signed({6'd0, lz});
		end
		return u;
	endfunction

	// round to nearest even and pack; value = m / 2^26 * 2^e, m[26] is the leading one
	function automatic logic [31:0] round_pack(input logic sign, input logic signed [10:0] e,
			input logic [26:0] m, input logic st);
		logic signed [11:0] be;
		logic signed [11:0] sh;
		logic [26:0] ms;
		logic [26:0] mask;
		logic [7:0] fld;
		logic st2;
		logic inc;
		logic [30:0] body;
		be = $signed({e[10], e}) + 12'sd127;
		sh = 12'sd1 - be;
		ms = m;
		fld = be[7:0];
		st2 = st;
		mask = '0;
		if (be < 12'sd1) begin
			// denormalize: shift right, fold lost bits into sticky
			fld = 8'd0;
			if (sh > 12'sd27) begin
				ms = '0;
				st2 = st | (|m);
			end else begin
				mask = (27'd1 << sh[4:0]) - 27'd1;
				ms = m >> sh[4:0];
				st2 = st | (|(m & mask));
			end
		end
		inc = ms[2] & (ms[3] | ms[1] | ms[0] | st2);
		// a carry out of the fraction bumps the exponent field
		body = {fld, ms[25:3]} + {30'd0, inc};
		if (be >= 12'sd255) body = {8'hff, 23'd0};
		return {sign, body};
	endfunction

	// exact 2*g, overflow to infinity
	function automatic logic [31:0] double_bits(input logic [31:0] b);
		logic [31:0] r;
		case (b[30:23])
			8'hff: r = b;
			8'hfe: r = {b[31], 8'hff, 23'd0};
			8'h00: r = {b[31], b[29:0], 1'b0};
			default: r = {b[31], b[30:23] + 8'd1, b[22:0]};
		endcase
		return r;
	endfunction

endpackage

// ===== src/fsmn_delay.sv =====
// Enabled delay line for operands that travel alongside the arithmetic units.
// No package dependencies.
module fsmn_delay #(
	parameter int W = 32,
	parameter int DEPTH = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] dly_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			dly_q[0] <= d;
			for (int i = 1; i < DEPTH; i++) begin
				dly_q[i] <= dly_q[i-1];
			end
		end
	end

	assign q = dly_q[DEPTH-1];

endmodule

// ===== src/fsmn_fmul.sv =====
// Three-stage binary32 multiplier: unpack, 24x24 product, normalize and round.
// Depends on fsmn_pkg.
module fsmn_fmul (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] y
);

	fsmn_pkg::fp_unp_t ua_s1, ub_s1;
	logic [47:0] p_s2;
	logic signed [10:0] e_s2;
	logic sign_s2, spec_s2;
	logic [31:0] specv_s2;
	logic [31:0] y_s3;

	logic [26:0] nm;
	logic nst;
	logic signed [10:0] ne;
	logic spec;
	logic [31:0] specv;

	always_comb begin
		spec = 1'b1;
		if (ua_s1.nan || ub_s1.nan || (ua_s1.inf && ub_s1.zero) || (ua_s1.zero && ub_s1.inf))
			specv = fsmn_pkg::CANON_NAN;
		else if (ua_s1.inf || ub_s1.inf)
			specv = {ua_s1.sign ^ ub_s1.sign, 8'hff, 23'd0};
		else if (ua_s1.zero || ub_s1.zero)
			specv = {ua_s1.sign ^ ub_s1.sign, 31'd0};
		else begin
			spec = 1'b0;
			specv = fsmn_pkg::CANON_NAN;
		end
	end

	always_comb begin
		if (p_s2[47]) begin
			nm = p_s2[47:21];
			nst = |p_s2[20:0];
			ne = e_s2 + 11'sd1;
		end else begin
			nm = p_s2[46:20];
			nst = |p_s2[19:0];
			ne = e_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ua_s1 <= fsmn_pkg::unpack(a);
			ub_s1 <= fsmn_pkg::unpack(b);
			p_s2 <= ua_s1.m * ub_s1.m;
			e_s2 <= ua_s1.e + ub_s1.e;
			sign_s2 <= ua_s1.sign ^ ub_s1.sign;
			spec_s2 <= spec;
			specv_s2 <= specv;
			y_s3 <= spec_s2 ? specv_s2 : fsmn_pkg::round_pack(sign_s2, ne, nm, nst);
		end
	end

	assign y = y_s3;

endmodule

// ===== src/fsmn_fsub.sv =====
// Five-stage binary32 subtractor y = a - b: unpack, order, align and add,
// normalize, round. Depends on fsmn_pkg.
module fsmn_fsub (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] y
);

	fsmn_pkg::fp_unp_t ua_s1, ub_s1;

	logic [23:0] big_m_s2, sml_m_s2;
	logic sml_zero_s2, sub_s2, sign_s2, spec_s2;
	logic [4:0] d_s2;
	logic signed [10:0] e_s2;
	logic [31:0] specv_s2;

	logic [27:0] sum_s3;
	logic signed [10:0] e_s3;
	logic sign_s3, spec_s3;
	logic [31:0] specv_s3;

	logic [26:0] m_s4;
	logic st_s4, zero_s4, sign_s4, spec_s4;
	logic signed [10:0] e_s4;
	logic [31:0] specv_s4;

	logic [31:0] y_s5;

	fsmn_pkg::fp_unp_t ua, ub, big, sml;
	logic a_big;
	logic signed [11:0] dif;
	logic [4:0] d5;
	logic spec;
	logic [31:0] specv;

	logic [26:0] xal, shf, mask, sm;
	logic lost;
	logic [27:0] sum;

	logic [26:0] nm;
	logic nst;
	logic signed [10:0] ne;
	logic [4:0] lz;

	// order operands by magnitude, subtrahend sign flipped
	always_comb begin
		ua = ua_s1;
		ub = ub_s1;
		ub.sign = ~ub_s1.sign;
		if (ua.zero) a_big = 1'b0;
		else if (ub.zero) a_big = 1'b1;
		else a_big = (ua.e > ub.e) || ((ua.e == ub.e) && (ua.m >= ub.m));
		big = a_big ? ua : ub;
		sml = a_big ? ub : ua;
		dif = $signed({big.e[10], big.e}) - $signed({sml.e[10], sml.e});
		d5 = (dif > 12'sd27) ? 5'd27 : dif[4:0];
		spec = 1'b1;
		if (ua.nan || ub.nan || (ua.inf && ub.inf && (ua.sign != ub.sign)))
			specv = fsmn_pkg::CANON_NAN;
		else if (ua.inf)
			specv = {ua.sign, 8'hff, 23'd0};
		else if (ub.inf)
			specv = {ub.sign, 8'hff, 23'd0};
		else if (ua.zero && ub.zero)
			specv = {ua.sign & ub.sign, 31'd0};
		else begin
			spec = 1'b0;
			specv = fsmn_pkg::CANON_NAN;
		end
	end

	// align the smaller operand, collapse shifted-out bits into the sticky lsb
	always_comb begin
		xal = {sml_m_s2, 3'b000};
		shf = xal >> d_s2;
		mask = (27'd1 << d_s2) - 27'd1;
		lost = |(xal & mask);
		sm = sml_zero_s2 ? 27'd0 : {shf[26:1], shf[0] | lost};
		if (sub_s2) sum = {1'b0, big_m_s2, 3'b000} - {1'b0, sm};
		else sum = {1'b0, big_m_s2, 3'b000} + {1'b0, sm};
	end

	always_comb begin
		lz = fsmn_pkg::lzc27(sum_s3[26:0]);
		if (sum_s3[27]) begin
			nm = sum_s3[27:1];
			nst = sum_s3[0];
			ne = e_s3 + 11'sd1;
		end else begin
			nm = sum_s3[26:0] << lz;
			nst = 1'b0;
			ne = e_s3 - $signed({6'd0, lz});
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ua_s1 <= fsmn_pkg::unpack(a);
			ub_s1 <= fsmn_pkg::unpack(b);

			big_m_s2 <= big.m;
			sml_m_s2 <= sml.m;
			sml_zero_s2 <= sml.zero;
			sub_s2 <= big.sign ^ sml.sign;
			sign_s2 <= big.sign;
			d_s2 <= d5;
			e_s2 <= big.e;
			spec_s2 <= spec;
			specv_s2 <= specv;

			sum_s3 <= sum;
			e_s3 <= e_s2;
			sign_s3 <= sign_s2;
			spec_s3 <= spec_s2;
			specv_s3 <= specv_s2;

			m_s4 <= nm;
			st_s4 <= nst;
			e_s4 <= ne;
			zero_s4 <= (sum_s3 == 28'd0);
			sign_s4 <= sign_s3;
			spec_s4 <= spec_s3;
			specv_s4 <= specv_s3;

			// exact cancellation gives +0
			if (spec_s4) y_s5 <= specv_s4;
			else if (zero_s4) y_s5 <= 32'd0;
			else y_s5 <= fsmn_pkg::round_pack(sign_s4, e_s4, m_s4, st_s4);
		end
	end

	assign y = y_s5;

endmodule

// ===== src/fsmn_fdiv.sv =====
// Binary32 divider y = a / b: unpack, prescale, one restoring quotient bit per stage,
// round. Depends on fsmn_pkg.
module fsmn_fdiv (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] y
);

	localparam int QB = fsmn_pkg::DIV_QB;

	fsmn_pkg::fp_unp_t ua_s1, ub_s1;

	// index 0 is the prescale stage, index k the stage after k quotient bits
	logic [25:0] rem_s [QB+1];
	logic [QB-1:0] quo_s [QB+1];
	logic [23:0] dvs_s [QB+1];
	logic signed [10:0] exp_s [QB+1];
	logic sign_s [QB+1];
	logic spec_s [QB+1];
	logic [31:0] specv_s [QB+1];

	logic [31:0] y_sr;

	logic ge [QB];
	logic [25:0] rd [QB];

	logic lt;
	logic spec;
	logic [31:0] specv;
	logic sgn;

	always_comb begin
		sgn = ua_s1.sign ^ ub_s1.sign;
		lt = ua_s1.m < ub_s1.m;
		spec = 1'b1;
		if (ua_s1.nan || ub_s1.nan || (ua_s1.zero && ub_s1.zero) || (ua_s1.inf && ub_s1.inf))
			specv = fsmn_pkg::CANON_NAN;
		else if (ua_s1.inf || ub_s1.zero)
			specv = {sgn, 8'hff, 23'd0};
		else if (ua_s1.zero || ub_s1.inf)
			specv = {sgn, 31'd0};
		else begin
			spec = 1'b0;
			specv = fsmn_pkg::CANON_NAN;
		end
	end

	always_comb begin
		for (int k = 0; k < QB; k++) begin
			ge[k] = rem_s[k] >= {2'b00, dvs_s[k]};
			rd[k] = ge[k] ? (rem_s[k] - {2'b00, dvs_s[k]}) : rem_s[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ua_s1 <= fsmn_pkg::unpack(a);
			ub_s1 <= fsmn_pkg::unpack(b);

			// prescale so the quotient lands in [1, 2)
			rem_s[0] <= lt ? {1'b0, ua_s1.m, 1'b0} : {2'b00, ua_s1.m};
			quo_s[0] <= '0;
			dvs_s[0] <= ub_s1.m;
			exp_s[0] <= ua_s1.e - ub_s1.e - (lt ? 11'sd1 : 11'sd0);
			sign_s[0] <= sgn;
			spec_s[0] <= spec;
			specv_s[0] <= specv;

			for (int k = 0; k < QB; k++) begin
				rem_s[k+1] <= {rd[k][24:0], 1'b0};
				quo_s[k+1] <= {quo_s[k][QB-2:0], ge[k]};
				dvs_s[k+1] <= dvs_s[k];
				exp_s[k+1] <= exp_s[k];
				sign_s[k+1] <= sign_s[k];
				spec_s[k+1] <= spec_s[k];
				specv_s[k+1] <= specv_s[k];
			end

			y_sr <= spec_s[QB] ? specv_s[QB] :
				fsmn_pkg::round_pack(sign_s[QB], exp_s[QB], quo_s[QB], rem_s[QB] != 26'd0);
		end
	end

	assign y = y_sr;

endmodule

// ===== src/fsmn_newton.sv =====
// One Newton step g' = g - (g*g - x) / (2*g) built from the pipelined units.
// Depends on fsmn_pkg, fsmn_fmul, fsmn_fsub, fsmn_fdiv, fsmn_delay.
module fsmn_newton (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] g_in,
	input  logic [31:0] x_in,
	output logic [31:0] g_out,
	output logic [31:0] x_out
);

	logic [31:0] sq, diff, quo, den;
	logic [31:0] x_d1, g_d1, g_d2;

	fsmn_fmul u_sq (.clk(clk), .en(en), .a(g_in), .b(g_in), .y(sq));

	fsmn_delay #(.W(32), .DEPTH(fsmn_pkg::MUL_LAT)) u_xd1 (
		.clk(clk), .en(en), .d(x_in), .q(x_d1)
	);

	fsmn_fsub u_diff (.clk(clk), .en(en), .a(sq), .b(x_d1), .y(diff));

	fsmn_delay #(.W(32), .DEPTH(fsmn_pkg::MUL_LAT + fsmn_pkg::ADD_LAT)) u_gd1 (
		.clk(clk), .en(en), .d(g_in), .q(g_d1)
	);

	assign den = fsmn_pkg::double_bits(g_d1);

	fsmn_fdiv u_quo (.clk(clk), .en(en), .a(diff), .b(den), .y(quo));

	fsmn_delay #(.W(32), .DEPTH(fsmn_pkg::DIV_LAT)) u_gd2 (
		.clk(clk), .en(en), .d(g_d1), .q(g_d2)
	);

	fsmn_fsub u_upd (.clk(clk), .en(en), .a(g_d2), .b(quo), .y(g_out));

	fsmn_delay #(.W(32), .DEPTH(2 * fsmn_pkg::ADD_LAT + fsmn_pkg::DIV_LAT)) u_xd2 (
		.clk(clk), .en(en), .d(x_d1), .q(x_out)
	);

endmodule

// ===== src/float_sqrt_magic_newton.sv =====
// Top level of the approximate binary32 square root pipeline.
// Depends on fsmn_pkg, fsmn_newton, fsmn_delay and the assertion macro header.
//
// Usage:
//   Request channel: value_bits (binary32 pattern) and last_in, taken when
//   in_valid and in_ready are both high. Result channel: root_bits and
//   last_out, delivered when out_valid and out_ready are both high.
//   The seed is (value_bits >> 1) + 0x1fbd1df5, refined by NEWTON_STEPS
//   Newton steps in full IEEE binary32 arithmetic; any NaN comes out as
//   0x7fc00000. last_in rides along unchanged.
//   Each step is a multiply, a subtract, a divide and a subtract; the divide
//   depth comes from its 27 restoring stages, one quotient bit each.
//   Throughput: one request per cycle while out_ready is high.
//   Stall: when a result waits with out_ready low, the whole pipeline holds
//   and in_ready drops; nothing is lost or repeated, and bubbles stay put.
//   Reset: arst_n clears all valid bits; the pipeline comes up empty.
`include "float_sqrt_magic_newton_macros.svh"

module float_sqrt_magic_newton #(
	parameter int NEWTON_STEPS = fsmn_pkg::NEWTON_STEPS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] value_bits,
	input  logic        last_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] root_bits,
	output logic        last_out
);

	localparam int LAT = 1 + NEWTON_STEPS * fsmn_pkg::STEP_LAT;

	logic en;
	logic [LAT-1:0] vld_q;
	logic [31:0] g_s1, x_s1;
	logic [31:0] g_c [NEWTON_STEPS+1];
	logic [31:0] x_c [NEWTON_STEPS+1];

	// advance everything unless a finished result is stuck at the output
	assign en = !vld_q[LAT-1] || out_ready;
	assign in_ready = en;
	assign out_valid = vld_q[LAT-1];

	// valid bits shift in lock-step with the data stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	// seed: logical shift plus magic constant on the integer view
	always_ff @(posedge clk) begin
		if (en) begin
			g_s1 <= {1'b0, value_bits[31:1]} + fsmn_pkg::SEED_ADD;
			x_s1 <= value_bits;
		end
	end

	assign g_c[0] = g_s1;
	assign x_c[0] = x_s1;

	for (genvar i = 0; i < NEWTON_STEPS; i++) begin : g_step
		fsmn_newton u_step (
			.clk(clk), .en(en), .g_in(g_c[i]), .x_in(x_c[i]),
			.g_out(g_c[i+1]), .x_out(x_c[i+1])
		);
	end

	assign root_bits = g_c[NEWTON_STEPS];

	// hold the last marker beside the arithmetic
	fsmn_delay #(.W(1), .DEPTH(LAT)) u_last (
		.clk(clk), .en(en), .d(last_in), .q(last_out)
	);

	`FSMN_ASSERT(a_stall_freeze, !en |=> $stable(vld_q), "pipeline moved while stalled")
	`FSMN_ASSERT(a_req_enters, (in_valid && in_ready) |=> vld_q[0], "accepted request lost")
	`FSMN_ASSERT(a_nan_canon,
		(out_valid && (root_bits[30:23] == 8'hff) && (root_bits[22:0] != 23'd0)) |->
		(root_bits == fsmn_pkg::CANON_NAN), "NaN result not canonical")
	`FSMN_ASSERT_ALWAYS(a_rst_empty, !arst_n |-> !out_valid, "result valid during reset")

endmodule

// ===== test/float_sqrt_magic_newton_tb.sv =====
// Self-checking testbench for the float_sqrt_magic_newton square root pipeline.
// Depends on fsmn_pkg and the float_sqrt_magic_newton RTL; the expected roots
// come from a binary32 predictor built here on double-precision arithmetic.
`timescale 1ns / 1ps

module float_sqrt_magic_newton_tb;

	localparam int ITEMS_PER_PHASE = 600;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 150;
	localparam int HOLD_CYCLES = 400;

	// one expected result
	typedef struct {
		logic [31:0] root;
		logic last;
	} root_exp_t;

	// Keeps the expected roots in order and checks each delivered result.
	class root_scoreboard;
		root_exp_t pending[$];
		int errors;

		function new();
			errors = 0;
		endfunction

		// widen binary32 bits to a real, exactly
		function real widen(logic [31:0] b);
			real r;
			if (b[30:23] == 8'hff)
				return $bitstoreal({b[31], 11'h7ff, (b[22:0] != 0) ? 52'h8000000000000 : 52'd0});
			if (b[30:0] == 0)
				return $bitstoreal({b[31], 63'd0});
			if (b[30:23] == 8'h00) begin
				r = real'(b[22:0]) / (2.0 ** 149);
				return b[31] ? -r : r;
			end
			return $bitstoreal({b[31], 3'b000, b[30:23] + 8'd0, b[22:0], 29'd0} +
				{1'b0, 11'd896, 52'd0});
		endfunction

		// round a real to binary32, nearest even; every NaN becomes the canonical one
		function logic [31:0] narrow(real r);
			logic [63:0] d;
			logic [63:0] m;
			logic [63:0] kept;
			logic [63:0] rem;
			logic [63:0] half;
			logic [63:0] body;
			int be;
			int shift;
			int eff;
			d = $realtobits(r);
			if (d[62:52] == 11'h7ff)
				return (d[51:0] != 0) ? fsmn_pkg::CANON_NAN : {d[63], 8'hff, 23'd0};
			// double subnormals lie far below the binary32 range
			if (d[62:52] == 11'h000)
				return {d[63], 31'd0};
			be = int'(d[62:52]) - 1023 + 127;
			m = {11'd1, d[51:0]};
			shift = (be >= 1) ? 29 : 30 - be;
			if (shift > 60)
				return {d[63], 31'd0};
			kept = m >> shift;
			rem = m & ((64'd1 << shift) - 64'd1);
			half = 64'd1 << (shift - 1);
			if (rem > half || (rem == half && kept[0]))
				kept = kept + 64'd1;
			eff = (be < 1) ? 1 : be;
			// a rounding carry walks into the exponent field on its own
			body = (64'(eff - 1) << 23) + kept;
			if (body >= 64'h7f800000)
				body = 64'h7f800000;
			return {d[63], body[30:0]};
		endfunction

		// seed from the integer view, then Newton steps in binary32
		function logic [31:0] approx_root(logic [31:0] x);
			logic [31:0] g;
			logic [31:0] sq;
			logic [31:0] diff;
			logic [31:0] den;
			logic [31:0] q;
			g = (x >> 1) + fsmn_pkg::SEED_ADD;
			for (int i = 0; i < fsmn_pkg::NEWTON_STEPS_DEF; i++) begin
				sq = narrow(widen(g) * widen(g));
				diff = narrow(widen(sq) - widen(x));
				den = narrow(2.0 * widen(g));
				if (den[30:0] == 0) begin
					// division by zero: NaN for 0/0 and NaN/0, else signed infinity
					if (diff[30:0] == 0 || (diff[30:23] == 8'hff && diff[22:0] != 0))
						q = fsmn_pkg::CANON_NAN;
					else
						q = {diff[31] ^ den[31], 8'hff, 23'd0};
				end else begin
					q = narrow(widen(diff) / widen(den));
				end
				g = narrow(widen(g) - widen(q));
			end
			return g;
		endfunction

		function void note_request(logic [31:0] value, logic last);
			root_exp_t e;
			e.root = approx_root(value);
			e.last = last;
			pending.push_back(e);
		endfunction

		function void check_result(logic [31:0] root, logic last);
			root_exp_t e;
			if (pending.size() == 0) begin
				$error("unexpected result root_bits=%h last_out=%b", root, last);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (root !== e.root) begin
				$error("root_bits: expected %h, got %h", e.root, root);
				errors++;
			end
			if (last !== e.last) begin
				$error("last_out: expected %b, got %b", e.last, last);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [31:0] value_bits;
	logic last_in;
	logic out_valid;
	logic out_ready;
	logic [31:0] root_bits;
	logic last_out;

	root_scoreboard roots;
	int send_idle_pct;
	int recv_idle_pct;
	bit hold_request;
	int hold_left;
	int cycles;

	float_sqrt_magic_newton uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.value_bits(value_bits),
		.last_in(last_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.root_bits(root_bits),
		.last_out(last_out)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Watchdog: stop a hung run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Sample both channels mid-cycle, where inputs and ready are settled;
	// the handshake then completes at the next rising edge.
	always @(negedge clk) begin
		if (arst_n && in_valid && in_ready)
			roots.note_request(value_bits, last_in);
		if (arst_n && out_valid && out_ready)
			roots.check_result(root_bits, last_out);
	end

	// Receiver: random stalls, plus one long hold-off when requested so the
	// pipeline fills up and pushes back on the sender.
	always @(posedge clk) begin
		if (hold_request && hold_left == 0) begin
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= (hold_left == 1);
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Offer one request, with random idle cycles ahead of it, and hold it
	// until accepted.
	task automatic send_request(logic [31:0] value, logic last);
		bit taken;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		value_bits <= value;
		last_in <= last;
		do begin
			@(negedge clk);
			taken = in_ready;
			@(posedge clk);
		end while (!taken);
	endtask

	// Random operand, weighted toward the interesting classes.
	function automatic logic [31:0] random_operand();
		logic [31:0] v;
		v = $urandom();
		case ($urandom_range(9))
			0: v[30:23] = 8'h00;                            // subnormal or zero
			1: v[30:23] = 8'hff;                            // inf or NaN
			2: v[30:23] = 8'(127 + $urandom_range(20) - 10); // near one
			3: v[30:0] = 31'($urandom_range(15));           // tiny patterns
			4: v[30:23] = 8'hfe;                            // top of range
			default: v[31] = ($urandom_range(9) == 0);      // mostly positive
		endcase
		return v;
	endfunction

	task automatic run_phase(int count, bit with_hold);
		for (int i = 0; i < count; i++) begin
			if (with_hold && i == count / 3)
				hold_request = 1'b1;
			if (with_hold && i == count / 3 + 5)
				hold_request = 1'b0;
			send_request(random_operand(), ($urandom_range(7) == 0));
		end
	endtask

	logic [31:0] corner_ops[] = '{
		32'h00000000, 32'h80000000, 32'h00000001, 32'h00000002, 32'h007fffff,
		32'h00800000, 32'h3f800000, 32'h40000000, 32'h40800000, 32'h3e800000,
		32'h7f7fffff, 32'h7f800000, 32'hff800000, 32'h7fc00000, 32'h7f800001,
		32'hffffffff, 32'hbf800000, 32'h80000001, 32'h807fffff, 32'hff7fffff,
		32'h55555555, 32'h2aaaaaaa, 32'h7ffffffe
	};

	initial begin
		roots = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		value_bits = '0;
		last_in = 1'b0;
		out_ready = 1'b0;
		hold_request = 1'b0;
		hold_left = 0;
		cycles = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners: zeros, subnormal and range limits, specials, negatives
		foreach (corner_ops[i])
			send_request(corner_ops[i], i[0]);

		send_idle_pct = 11;
		recv_idle_pct = 80;
		run_phase(ITEMS_PER_PHASE, 1'b0);
		send_idle_pct = 80;
		recv_idle_pct = 11;
		run_phase(ITEMS_PER_PHASE, 1'b0);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_phase(ITEMS_PER_PHASE, 1'b1);
		in_valid <= 1'b0;

		// drain, then allow for stragglers the latency could still deliver
		while (roots.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (roots.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
